// File: sv/mmc_pkg.sv
// Shared types and constants of the masked magic classifier.
package mmc_pkg;

    typedef enum logic [2:0] {
        OP_HEADER  = 3'd0,
        OP_PATTERN = 3'd1,
        OP_ENABLE  = 3'd2,
        OP_DELETE  = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_HBYTE   = 3'd5,
        OP_SPARE6  = 3'd6,
        OP_SPARE7  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SLOT,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    localparam logic [7:0] MAGIC_CLEAR = 8'h00;
    localparam logic [7:0] MASK_CLEAR  = 8'hff;

    // Table command: only legal, in-range commands are issued.
    typedef struct packed {
        logic       valid;
        op_t        op;
        logic [7:0] slot;
        logic       en;
        logic [6:0] offset;
        logic [7:0] length;
        logic [2:0] flags;
    } slot_cmd_t;

    typedef struct packed {
        logic       valid;
        logic       enabled;
        logic [6:0] offset;
        logic [7:0] length;
        logic [2:0] flags;
        logic [7:0] age;
    } slot_info_t;

endpackage

// File: sv/mmc_ram.sv
// Generic simple dual-port RAM with registered read.
module mmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mmc_slot_table.sv
// Rule slot headers, enables and age ranks.
module mmc_slot_table #(
    parameter int NUM_SLOTS = 16,
    parameter int SW        = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mmc_pkg::slot_cmd_t    cmd,
    input  logic [SW-1:0]         rd_idx,
    output mmc_pkg::slot_info_t   info
);

    logic       valid_reg   [NUM_SLOTS];
    logic       valid_next  [NUM_SLOTS];
    logic       enable_reg  [NUM_SLOTS];
    logic       enable_next [NUM_SLOTS];
    logic [7:0] age_reg     [NUM_SLOTS];
    logic [7:0] age_next    [NUM_SLOTS];
    logic [6:0] offset_reg  [NUM_SLOTS];
    logic [7:0] length_reg  [NUM_SLOTS];
    logic [2:0] flags_reg   [NUM_SLOTS];
    logic [SW-1:0] s;

    assign s = SW'(cmd.slot);

    always_comb begin
        valid_next  = valid_reg;
        enable_next = enable_reg;
        age_next    = age_reg;
        if (cmd.valid) begin
            unique case (cmd.op)
                mmc_pkg::OP_HEADER: begin
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        // older than the replaced entry keeps its rank, rest age by one
                        if (valid_reg[k] && !(valid_reg[s] && age_reg[k] > age_reg[s])) begin
                            age_next[k] = age_reg[k] + 8'd1;
                        end
                    end
                    valid_next[s]  = 1'b1;
                    enable_next[s] = cmd.en;
                    age_next[s]    = 8'd0;
                end
                mmc_pkg::OP_ENABLE: begin
                    if (valid_reg[s]) begin
                        enable_next[s] = cmd.en;
                    end
                end
                mmc_pkg::OP_DELETE: begin
                    if (valid_reg[s]) begin
                        for (int k = 0; k < NUM_SLOTS; k++) begin
                            if (valid_reg[k] && age_reg[k] > age_reg[s]) begin
                                age_next[k] = age_reg[k] - 8'd1;
                            end
                        end
                        valid_next[s]  = 1'b0;
                        enable_next[s] = 1'b0;
                    end
                end
                mmc_pkg::OP_CLEAR: begin
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        valid_next[k]  = 1'b0;
                        enable_next[k] = 1'b0;
                        age_next[k]    = 8'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                valid_reg[k]  <= 1'b0;
                enable_reg[k] <= 1'b0;
                age_reg[k]    <= 8'd0;
            end
        end else begin
            valid_reg  <= valid_next;
            enable_reg <= enable_next;
            age_reg    <= age_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.valid && cmd.op == mmc_pkg::OP_HEADER) begin
            offset_reg[s] <= cmd.offset;
            length_reg[s] <= cmd.length;
            flags_reg[s]  <= cmd.flags;
        end
    end

    always_comb begin
        info.valid   = valid_reg[rd_idx];
        info.enabled = enable_reg[rd_idx];
        info.offset  = offset_reg[rd_idx];
        info.length  = length_reg[rd_idx];
        info.flags   = flags_reg[rd_idx];
        info.age     = age_reg[rd_idx];
    end

endmodule

// File: sv/masked_magic_classifier.sv
// Top level: command decode, pattern and header memories, match sequencer.
//
//  channel   | handshake               | payload
//  s_ (in)   | s_tvalid/s_tready       | tdata rule/byte fields, tuser opcode, tlast last byte
//  m_ (out)  | m_tvalid/m_tready       | tdata hit, hit_slot, hit_flags
//  cfg       | cfg_we                  | cfg_wdata global enable
//
// A header load also clears the slot's pattern row, all HEADER_BYTES entries of it.
// A match (global enable set) tests the enabled slots in turn; the pattern and
// header memories are read one byte at a time, compared in the state after the read.
// s_tready is low while a clear or match runs; a finished result waits in the
// output register, and a further result waits until that word is taken.
module masked_magic_classifier #(
    parameter int NUM_SLOTS    = 16,
    parameter int HEADER_BYTES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[3:0] byte_index[10:4] data_byte[18:11] mask_byte[26:19] rule_offset[33:27]
    // rule_length[41:34] rule_flags[44:42] enable_bit[45] zero[47:46]
    input  logic [47:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit[0] hit_slot[4:1] hit_flags[7:5]
    output logic [7:0]  m_tdata
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int JW = $clog2(HEADER_BYTES);
    localparam int LW = $clog2(HEADER_BYTES + 1);
    localparam int PAT_DEPTH = NUM_SLOTS * (2 ** JW);

    logic [3:0] in_slot;
    logic [6:0] in_idx;
    logic [7:0] in_data, in_mask, in_len;
    logic [6:0] in_off;
    logic [2:0] in_flags, in_op;
    logic       in_en;

    assign in_slot  = s_tdata[3:0];
    assign in_idx   = s_tdata[10:4];
    assign in_data  = s_tdata[18:11];
    assign in_mask  = s_tdata[26:19];
    assign in_off   = s_tdata[33:27];
    assign in_len   = s_tdata[41:34];
    assign in_flags = s_tdata[44:42];
    assign in_en    = s_tdata[45];
    assign in_op    = s_tuser;

    mmc_pkg::state_t state_reg, state_next;
    logic [SW-1:0]   k_reg, k_next, best_reg, best_next, sweep_slot_reg, sweep_slot_next;
    logic [LW-1:0]   j_reg, j_next;
    logic            found_reg, found_next;
    logic [7:0]      best_age_reg, best_age_next;
    logic [2:0]      best_flags_reg, best_flags_next;
    logic            genable_reg;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_data_reg, m_data_next;

    logic accept, slot_ok, idx_ok, hdr_ok, last_k, eligible, mismatch;
    mmc_pkg::slot_cmd_t  cmd;
    mmc_pkg::slot_info_t info;

    logic                         pat_we;
    logic [$clog2(PAT_DEPTH)-1:0] pat_waddr, pat_raddr;
    logic [15:0]                  pat_wdata, pat_rdata;
    logic                         hdr_we;
    logic [JW-1:0]                hdr_raddr;
    logic [7:0]                   hdr_rdata;

    assign s_tready = (state_reg == mmc_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign slot_ok  = 32'(in_slot) < NUM_SLOTS;
    assign idx_ok   = 32'(in_idx) < HEADER_BYTES;
    assign hdr_ok   = (in_len != 8'd0) && (32'(in_off) + 32'(in_len) <= HEADER_BYTES);
    assign last_k   = 32'(k_reg) == NUM_SLOTS - 1;
    assign eligible = info.valid && info.enabled && (!found_reg || info.age < best_age_reg);
    assign mismatch = ((hdr_rdata ^ pat_rdata[15:8]) & pat_rdata[7:0]) != 8'd0;

    always_comb begin
        cmd        = '0;
        cmd.op     = mmc_pkg::op_t'(in_op);
        cmd.slot   = 8'(in_slot);
        cmd.en     = in_en;
        cmd.offset = in_off;
        cmd.length = in_len;
        cmd.flags  = in_flags;
        cmd.valid  = accept && slot_ok && (in_op <= mmc_pkg::OP_DELETE)
                     && (in_op != mmc_pkg::OP_PATTERN)
                     && (in_op != mmc_pkg::OP_HEADER || hdr_ok);
        if (accept && in_op == mmc_pkg::OP_CLEAR) begin
            cmd.valid = 1'b1;
        end
    end

    mmc_slot_table #(.NUM_SLOTS(NUM_SLOTS), .SW(SW)) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_idx  (k_reg),
        .info    (info)
    );

    // Pattern row: magic in the upper byte, mask in the lower.
    always_comb begin
        if (state_reg == mmc_pkg::ST_SWEEP) begin
            pat_we    = 1'b1;
            pat_waddr = {sweep_slot_reg, j_reg[JW-1:0]};
            pat_wdata = {mmc_pkg::MAGIC_CLEAR, mmc_pkg::MASK_CLEAR};
        end else begin
            pat_we    = accept && in_op == mmc_pkg::OP_PATTERN && slot_ok && idx_ok;
            pat_waddr = {SW'(in_slot), JW'(in_idx)};
            pat_wdata = {in_data, in_mask};
        end
    end

    assign pat_raddr = {k_reg, j_reg[JW-1:0]};
    assign hdr_we    = accept && in_op == mmc_pkg::OP_HBYTE && idx_ok;
    assign hdr_raddr = JW'(info.offset) + j_reg[JW-1:0];

    mmc_ram #(.WIDTH(16), .DEPTH(PAT_DEPTH)) u_pattern (
        .aclk  (aclk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (pat_wdata),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    mmc_ram #(.WIDTH(8), .DEPTH(2 ** JW)) u_header (
        .aclk  (aclk),
        .we    (hdr_we),
        .waddr (JW'(in_idx)),
        .wdata (in_data),
        .raddr (hdr_raddr),
        .rdata (hdr_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        best_age_next   = best_age_reg;
        best_flags_next = best_flags_reg;
        sweep_slot_next = sweep_slot_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        unique case (state_reg)
            mmc_pkg::ST_IDLE: begin
                if (accept && in_op == mmc_pkg::OP_HEADER && slot_ok && hdr_ok) begin
                    sweep_slot_next = SW'(in_slot);
                    j_next          = '0;
                    state_next      = mmc_pkg::ST_SWEEP;
                end else if (accept && in_op == mmc_pkg::OP_HBYTE && s_tlast) begin
                    k_next     = '0;
                    found_next = 1'b0;
                    state_next = genable_reg ? mmc_pkg::ST_SLOT : mmc_pkg::ST_DONE;
                end
            end
            mmc_pkg::ST_SWEEP: begin
                j_next = j_reg + LW'(1);
                if (32'(j_reg) == HEADER_BYTES - 1) begin
                    state_next = mmc_pkg::ST_IDLE;
                end
            end
            mmc_pkg::ST_SLOT: begin
                j_next = '0;
                if (eligible) begin
                    state_next = mmc_pkg::ST_READ;
                end else if (last_k) begin
                    state_next = mmc_pkg::ST_DONE;
                end else begin
                    k_next = k_reg + SW'(1);
                end
            end
            mmc_pkg::ST_READ: begin
                state_next = mmc_pkg::ST_CMP;
            end
            mmc_pkg::ST_CMP: begin
                if (!mismatch && 9'(j_reg) + 9'd1 != 9'(info.length)) begin
                    j_next     = j_reg + LW'(1);
                    state_next = mmc_pkg::ST_READ;
                end else begin
                    if (!mismatch) begin
                        found_next      = 1'b1;
                        best_next       = k_reg;
                        best_age_next   = info.age;
                        best_flags_next = info.flags;
                    end
                    if (last_k) begin
                        state_next = mmc_pkg::ST_DONE;
                    end else begin
                        k_next     = k_reg + SW'(1);
                        state_next = mmc_pkg::ST_SLOT;
                    end
                end
            end
            mmc_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = found_reg ? {best_flags_reg, 4'(best_reg), 1'b1} : 8'd0;
                    state_next   = mmc_pkg::ST_IDLE;
                end
            end
            default: state_next = mmc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mmc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            genable_reg <= 1'b1;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            if (cfg_we) begin
                genable_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg          <= k_next;
        j_reg          <= j_next;
        best_reg       <= best_next;
        best_age_reg   <= best_age_next;
        best_flags_reg <= best_flags_next;
        sweep_slot_reg <= sweep_slot_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: tb/tb_masked_magic_classifier.sv
// Self-checking testbench of the masked magic classifier: rule loads, header streams, match results.
module tb_masked_magic_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS  = 16;
    localparam int HBYTES = 128;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [2:0] flags;
        logic [3:0] slot;
        logic       hit;
    } verdict_t;

    // Mirror of the rule table and header buffer; predicts match verdicts.
    class rule_scoreboard;
        bit         valid   [SLOTS];
        bit         enabled [SLOTS];
        bit [6:0]   offset  [SLOTS];
        bit [7:0]   length  [SLOTS];
        bit [2:0]   flags   [SLOTS];
        int         rank    [SLOTS];
        bit [7:0]   magic   [SLOTS][HBYTES];
        bit [7:0]   mask    [SLOTS][HBYTES];
        bit [7:0]   header  [HBYTES];
        bit         gen;
        verdict_t   pending [$];
        int         errors;

        function new();
            gen = 1'b1;
            errors = 0;
            foreach (valid[s]) begin
                valid[s] = 0; enabled[s] = 0; rank[s] = 0;
                foreach (mask[s][j]) begin
                    mask[s][j] = 8'hff; magic[s][j] = 8'h00;
                end
            end
            foreach (header[i]) header[i] = 8'h00;
        endfunction

        function void retire(int s);
            if (!valid[s]) return;
            foreach (valid[k]) if (valid[k] && rank[k] > rank[s]) rank[k]--;
            valid[s] = 0;
            enabled[s] = 0;
        endfunction

        function bit rule_fits(int s);
            for (int j = 0; j < length[s]; j++) begin
                if (offset[s] + j >= HBYTES) break;
                if (((header[offset[s] + j] ^ magic[s][j]) & mask[s][j]) != 0) return 0;
            end
            return 1;
        endfunction

        function void note_word(mmc_pkg::op_t op, bit [3:0] s, bit [6:0] idx,
                                bit [7:0] data, bit [7:0] msk, bit [6:0] off,
                                bit [7:0] len, bit [2:0] flg, bit en, bit last);
            verdict_t v;
            int best;
            case (op)
                mmc_pkg::OP_HEADER: begin
                    if (len == 0 || int'(off) + int'(len) > HBYTES) return;
                    retire(s);
                    foreach (valid[k]) if (valid[k]) rank[k]++;
                    valid[s] = 1; enabled[s] = en; offset[s] = off; length[s] = len;
                    flags[s] = flg; rank[s] = 0;
                    foreach (magic[s][j]) begin
                        magic[s][j] = 8'h00; mask[s][j] = 8'hff;
                    end
                end
                mmc_pkg::OP_PATTERN: begin
                    magic[s][idx] = data; mask[s][idx] = msk;
                end
                mmc_pkg::OP_ENABLE: if (valid[s]) enabled[s] = en;
                mmc_pkg::OP_DELETE: retire(s);
                mmc_pkg::OP_CLEAR: foreach (valid[k]) begin
                    valid[k] = 0; enabled[k] = 0; rank[k] = 0;
                end
                mmc_pkg::OP_HBYTE: begin
                    header[idx] = data;
                    if (!last) return;
                    best = -1;
                    if (gen) foreach (valid[k]) begin
                        if (!valid[k] || !enabled[k]) continue;
                        if (best >= 0 && rank[k] >= rank[best]) continue;
                        if (rule_fits(k)) best = k;
                    end
                    v = '0;
                    if (best >= 0) begin
                        v.hit = 1; v.slot = best[3:0]; v.flags = flags[best];
                    end
                    pending.push_back(v);
                end
                default: ;
            endcase
        endfunction

        function void check_word(verdict_t got);
            verdict_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit || got.slot !== want.slot || got.flags !== want.flags) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected hit=%0d slot=%0d flags=%0d, got hit=%0d slot=%0d flags=%0d",
                             want.hit, want.slot, want.flags, got.hit, got.slot, got.flags);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic        cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;

    rule_scoreboard board = new();
    int  send_idle = 0, take_idle = 0;
    longint cycles = 0;

    masked_magic_classifier u_dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (aresetn && m_tvalid && m_tready) board.check_word(verdict_t'(m_tdata));
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Random receiver stall, changed at the falling edge.
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= take_idle);

    // Hold tvalid high from one word to the next; drop it only while idling.
    task automatic send_word(mmc_pkg::op_t op, bit [3:0] s, bit [6:0] idx, bit [7:0] data,
                             bit [7:0] msk, bit [6:0] off, bit [7:0] len,
                             bit [2:0] flg, bit en, bit last);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {2'b00, en, flg, len, off, msk, data, idx, s};
        do @(posedge aclk); while (!s_tready);
        board.note_word(op, s, idx, data, msk, off, len, flg, en, last);
        @(negedge aclk);
    endtask

    // Fill the header buffer so no match ever reads an unwritten byte.
    task automatic fill_header(bit last);
        for (int i = 0; i < HBYTES; i++)
            send_word(mmc_pkg::OP_HBYTE, 0, 7'(i), 8'($urandom), 0, 0, 0, 0, 0,
                      last && i == HBYTES - 1);
    endtask

    task automatic write_enable(bit v);
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        cfg_we <= 1; cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 0;
        board.gen = v;
    endtask

    // A rule copied from the current header with random mask holes, so it often hits.
    task automatic load_rule(bit [3:0] s, bit exact);
        bit [7:0] len = 8'($urandom_range(1, $urandom_range(3) == 0 ? 128 : 6));
        bit [6:0] off = 7'($urandom_range(0, HBYTES - len));
        send_word(mmc_pkg::OP_HEADER, s, 0, 0, 0, off, len, 3'($urandom),
                  $urandom_range(9) != 0, 0);
        for (int j = 0; j < len && j < 6; j++) begin
            bit [7:0] m = $urandom_range(3) == 0 ? 8'($urandom) : 8'hff;
            bit [7:0] d = board.header[off + j];
            if (!exact) d ^= 8'($urandom_range(0, 1) << $urandom_range(7));
            send_word(mmc_pkg::OP_PATTERN, s, 7'(j), d, m, 0, 0, 0, 0, 0);
        end
    endtask

    task automatic random_word();
        int pick = $urandom_range(99);
        if (pick < 30) load_rule(4'($urandom), $urandom_range(3) != 0);
        else if (pick < 40) send_word(mmc_pkg::OP_PATTERN, 4'($urandom), 7'($urandom),
                                      8'($urandom), 8'($urandom), 0, 0, 0, 0, 0);
        else if (pick < 48) send_word(mmc_pkg::OP_ENABLE, 4'($urandom), 0, 0, 0, 0, 0, 0,
                                      1'($urandom), 0);
        else if (pick < 55) send_word(mmc_pkg::OP_DELETE, 4'($urandom), 0, 0, 0, 0, 0, 0,
                                      0, 0);
        else if (pick < 57) send_word(mmc_pkg::OP_CLEAR, 4'($urandom), 0, 0, 0, 0, 0, 0,
                                      0, 0);
        else if (pick < 59) send_word($urandom_range(1) == 0 ? mmc_pkg::OP_SPARE6
                                                             : mmc_pkg::OP_SPARE7,
                                      4'($urandom), 7'($urandom), 8'($urandom),
                                      8'($urandom), 7'($urandom), 8'($urandom),
                                      3'($urandom), 1'($urandom), 1'($urandom));
        else if (pick < 62) send_word(mmc_pkg::OP_HEADER, 4'($urandom), 0, 0, 0,
                                      7'($urandom_range(64, 127)),
                                      8'($urandom_range(65, 255)), 3'($urandom), 1, 0);
        else send_word(mmc_pkg::OP_HBYTE, 0, 7'($urandom), 8'($urandom), 8'($urandom),
                       7'($urandom), 8'($urandom), 3'($urandom), 1'($urandom),
                       $urandom_range(2) == 0);
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: header, extremes, every operation
        fill_header(1);
        send_word(mmc_pkg::OP_HBYTE, 0, 127, 8'hff, 0, 0, 0, 0, 0, 1);
        send_word(mmc_pkg::OP_HEADER, 15, 0, 0, 0, 0, 128, 7, 1, 0);
        send_word(mmc_pkg::OP_HBYTE, 0, 0, 8'h4d, 0, 0, 0, 0, 0, 1);
        send_word(mmc_pkg::OP_HEADER, 0, 0, 0, 0, 127, 1, 3, 1, 0);
        send_word(mmc_pkg::OP_PATTERN, 0, 0, 8'hff, 8'h00, 0, 0, 0, 0, 0);
        send_word(mmc_pkg::OP_HEADER, 3, 0, 0, 0, 1, 128, 1, 1, 0);
        send_word(mmc_pkg::OP_HEADER, 4, 0, 0, 0, 0, 0, 1, 1, 0);
        send_word(mmc_pkg::OP_HBYTE, 0, 5, 8'h00, 0, 0, 0, 0, 0, 1);
        send_word(mmc_pkg::OP_ENABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(mmc_pkg::OP_ENABLE, 9, 0, 0, 0, 0, 0, 0, 1, 0);
        send_word(mmc_pkg::OP_HBYTE, 0, 1, 8'h5a, 0, 0, 0, 0, 0, 1);
        send_word(mmc_pkg::OP_DELETE, 15, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(mmc_pkg::OP_DELETE, 9, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(mmc_pkg::OP_ENABLE, 0, 0, 0, 0, 0, 0, 0, 1, 0);
        send_word(mmc_pkg::OP_HBYTE, 0, 2, 8'h11, 0, 0, 0, 0, 0, 1);
        send_word(mmc_pkg::OP_SPARE7, 15, 127, 8'hff, 8'hff, 127, 8'hff, 7, 1, 1);
        send_word(mmc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(mmc_pkg::OP_HBYTE, 0, 3, 8'h22, 0, 0, 0, 0, 0, 1);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = phase == 0 ? 35 : phase == 1 ? 54 : 0;
            take_idle = phase == 0 ? 54 : phase == 1 ? 35 : 0;
            write_enable(phase != 1 ? 1'b0 : 1'b1);
            for (int n = 0; n < 20; n++) random_word();
            write_enable(1'b1);
            for (int n = 0; n < 100; n++) random_word();
        end

        s_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (600) @(negedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
